>>> rtl/core/matrix4_column_transform_core_defines.svh
// Assertion macros used by the checker of the column transform core.
`ifndef MATRIX4_COLUMN_TRANSFORM_CORE_DEFINES_SVH
`define MATRIX4_COLUMN_TRANSFORM_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define M4CT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define M4CT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/m4ct_pkg.sv
// Types and constants shared by the column transform core and its cells.
package m4ct_pkg;

    localparam int ROWS   = 4;
    localparam int COL_W  = 2;
    localparam int ELEM_W = 32;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_XFORM = 1'b1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
    localparam elem_t ELEM_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic             kind;
        logic [COL_W-1:0] col;
    } beat_ctrl_t;

endpackage

>>> rtl/core/matrix4_column_transform_core.sv
// A transform beat is registered in each cell's multiply and add stages, then in the clamp
// stage. Throughput: one beat per cycle, loads and transforms alike, unless out_stall holds
// the result; four column cells of two stages each (multiply, then add) and one clamp stage
// form an elastic pipeline. A load beat updates the column store when it reaches its cell
// and leaves no result. Reset (rst_n, asynchronous, active low) empties the pipeline and
// clears the whole left-matrix store to zero.
module matrix4_column_transform_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid,
    output logic                               stall,
    input  logic                               kind,
    input  logic [m4ct_pkg::COL_W-1:0]         col,
    input  m4ct_pkg::elem_t                    elem_zero,
    input  m4ct_pkg::elem_t                    elem_one,
    input  m4ct_pkg::elem_t                    elem_two,
    input  m4ct_pkg::elem_t                    elem_three,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [m4ct_pkg::COL_W-1:0]         out_col,
    output m4ct_pkg::elem_t                    res_zero,
    output m4ct_pkg::elem_t                    res_one,
    output m4ct_pkg::elem_t                    res_two,
    output m4ct_pkg::elem_t                    res_three,
    output logic                               saturated
);

    localparam int CELLS = m4ct_pkg::ROWS;

    logic                 chain_valid [CELLS+1];
    logic                 chain_ready [CELLS+1];
    m4ct_pkg::beat_ctrl_t chain_ctrl  [CELLS+1];
    m4ct_pkg::elem_t      chain_vec   [CELLS+1][m4ct_pkg::ROWS];
    m4ct_pkg::sum_t       chain_psum  [CELLS+1][m4ct_pkg::ROWS];
    m4ct_pkg::elem_t      res         [m4ct_pkg::ROWS];

    assign chain_valid[0]     = valid;
    assign chain_ctrl[0].kind = kind;
    assign chain_ctrl[0].col  = col;
    assign chain_vec[0][0]    = elem_zero;
    assign chain_vec[0][1]    = elem_one;
    assign chain_vec[0][2]    = elem_two;
    assign chain_vec[0][3]    = elem_three;
    assign stall              = !chain_ready[0];

    assign chain_psum[0] = '{default: '0};

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        m4ct_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (m4ct_pkg::COL_W'(i)),
            .up_valid   (chain_valid[i]),
            .up_ready   (chain_ready[i]),
            .up_ctrl    (chain_ctrl[i]),
            .up_vec     (chain_vec[i]),
            .up_psum    (chain_psum[i]),
            .down_valid (chain_valid[i+1]),
            .down_ready (chain_ready[i+1]),
            .down_ctrl  (chain_ctrl[i+1]),
            .down_vec   (chain_vec[i+1]),
            .down_psum  (chain_psum[i+1])
        );
    end

    m4ct_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CELLS]),
        .in_ready  (chain_ready[CELLS]),
        .in_ctrl   (chain_ctrl[CELLS]),
        .in_psum   (chain_psum[CELLS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_col   (out_col),
        .res       (res),
        .saturated (saturated)
    );

    assign res_zero  = res[0];
    assign res_one   = res[1];
    assign res_two   = res[2];
    assign res_three = res[3];

endmodule

>>> rtl/core/m4ct_cell.sv
// One column cell: holds one left-matrix column and adds its products to the passing sums.
module m4ct_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [m4ct_pkg::COL_W-1:0]         cell_idx,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  m4ct_pkg::beat_ctrl_t               up_ctrl,
    input  m4ct_pkg::elem_t                    up_vec [m4ct_pkg::ROWS],
    input  m4ct_pkg::sum_t                     up_psum [m4ct_pkg::ROWS],
    output logic                               down_valid,
    input  logic                               down_ready,
    output m4ct_pkg::beat_ctrl_t               down_ctrl,
    output m4ct_pkg::elem_t                    down_vec [m4ct_pkg::ROWS],
    output m4ct_pkg::sum_t                     down_psum [m4ct_pkg::ROWS]
);

    m4ct_pkg::elem_t      col_store_reg [m4ct_pkg::ROWS];

    logic                 a_valid_reg;
    m4ct_pkg::beat_ctrl_t a_ctrl_reg;
    m4ct_pkg::elem_t      a_vec_reg  [m4ct_pkg::ROWS];
    m4ct_pkg::prod_t      a_prod_reg [m4ct_pkg::ROWS];
    m4ct_pkg::sum_t       a_psum_reg [m4ct_pkg::ROWS];
    m4ct_pkg::prod_t      a_prod_next [m4ct_pkg::ROWS];

    logic                 b_valid_reg;
    m4ct_pkg::beat_ctrl_t b_ctrl_reg;
    m4ct_pkg::elem_t      b_vec_reg  [m4ct_pkg::ROWS];
    m4ct_pkg::sum_t       b_psum_reg [m4ct_pkg::ROWS];

    logic                 a_ready;
    logic                 b_ready;
    logic                 up_fire;
    logic                 a_fire;
    logic                 load_hit;

    assign b_ready  = !b_valid_reg || down_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;
    assign up_fire  = up_valid && a_ready;
    assign a_fire   = a_valid_reg && b_ready;
    assign load_hit = up_fire && (up_ctrl.kind == m4ct_pkg::KIND_LOAD)
                      && (up_ctrl.col == cell_idx);

    // Each row multiplies its stored element by the vector element that matches this column.
    always_comb
    begin
        for (int r = 0; r < m4ct_pkg::ROWS; r++)
        begin
            a_prod_next[r] = m4ct_pkg::PROD_W'(col_store_reg[r])
                             * m4ct_pkg::PROD_W'(up_vec[cell_idx]);
        end
    end

    // A load travels down the chain like any beat, so transforms behind it see the new column.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < m4ct_pkg::ROWS; r++)
            begin
                col_store_reg[r] <= '0;
            end
        end
        else if (load_hit)
        begin
            for (int r = 0; r < m4ct_pkg::ROWS; r++)
            begin
                col_store_reg[r] <= up_vec[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_fire)
        begin
            a_ctrl_reg <= up_ctrl;
            for (int r = 0; r < m4ct_pkg::ROWS; r++)
            begin
                a_vec_reg[r]  <= up_vec[r];
                a_prod_reg[r] <= a_prod_next[r];
                a_psum_reg[r] <= up_psum[r];
            end
        end
        if (a_fire)
        begin
            b_ctrl_reg <= a_ctrl_reg;
            for (int r = 0; r < m4ct_pkg::ROWS; r++)
            begin
                b_vec_reg[r]  <= a_vec_reg[r];
                b_psum_reg[r] <= a_psum_reg[r] + m4ct_pkg::SUM_W'(a_prod_reg[r]);
            end
        end
    end

    assign down_valid = b_valid_reg;
    assign down_ctrl  = b_ctrl_reg;
    assign down_vec   = b_vec_reg;
    assign down_psum  = b_psum_reg;

endmodule

>>> rtl/core/m4ct_sat.sv
// Output stage: scales the row sums down, clamps them to 32 bits and holds the result beat.
module m4ct_sat #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  m4ct_pkg::beat_ctrl_t               in_ctrl,
    input  m4ct_pkg::sum_t                     in_psum [m4ct_pkg::ROWS],
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [m4ct_pkg::COL_W-1:0]         out_col,
    output m4ct_pkg::elem_t                    res [m4ct_pkg::ROWS],
    output logic                               saturated
);

    localparam int TOP_W = m4ct_pkg::SUM_W - m4ct_pkg::ELEM_W + 1;

    logic                              out_valid_reg;
    logic [m4ct_pkg::COL_W-1:0]        out_col_reg;
    m4ct_pkg::elem_t                   res_reg  [m4ct_pkg::ROWS];
    m4ct_pkg::elem_t                   res_next [m4ct_pkg::ROWS];
    logic                              sat_reg;
    logic                              sat_next;
    logic                              in_fire;

    assign in_ready = !out_valid_reg || !out_stall;
    assign in_fire  = in_valid && in_ready;

    // The arithmetic shift rounds toward minus infinity; the row fits when the bits from
    // bit 31 upward are all equal.
    always_comb
    begin
        m4ct_pkg::sum_t   shifted;
        logic [TOP_W-1:0] top;
        sat_next = 1'b0;
        for (int r = 0; r < m4ct_pkg::ROWS; r++)
        begin
            shifted = in_psum[r] >>> FRAC_BITS;
            top     = shifted[m4ct_pkg::SUM_W-1:m4ct_pkg::ELEM_W-1];
            if (!top[TOP_W-1] && (|top))
            begin
                res_next[r] = m4ct_pkg::ELEM_MAX;
                sat_next    = 1'b1;
            end
            else if (top[TOP_W-1] && !(&top))
            begin
                res_next[r] = m4ct_pkg::ELEM_MIN;
                sat_next    = 1'b1;
            end
            else
            begin
                res_next[r] = shifted[m4ct_pkg::ELEM_W-1:0];
            end
        end
    end

    // Load beats end here and leave no result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_fire && (in_ctrl.kind == m4ct_pkg::KIND_XFORM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_col_reg <= in_ctrl.col;
            sat_reg     <= sat_next;
            for (int r = 0; r < m4ct_pkg::ROWS; r++)
            begin
                res_reg[r] <= res_next[r];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_col   = out_col_reg;
    assign res       = res_reg;
    assign saturated = sat_reg;

endmodule

>>> rtl/core/m4ct_checker.sv
// Port-level checker for the column transform core, bound to the top level.
`include "matrix4_column_transform_core_defines.svh"

module m4ct_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            stall,
    input logic            out_valid,
    input logic            out_stall,
    input m4ct_pkg::elem_t res_zero,
    input m4ct_pkg::elem_t res_one,
    input m4ct_pkg::elem_t res_two,
    input m4ct_pkg::elem_t res_three,
    input logic            saturated
);

    logic [4*m4ct_pkg::ELEM_W:0] res_bits;
    logic                        out_blocked;
    logic                        at_bound;

    assign res_bits    = {res_zero, res_one, res_two, res_three, saturated};
    assign out_blocked = out_valid && out_stall;
    assign at_bound    = (res_zero == m4ct_pkg::ELEM_MAX) || (res_zero == m4ct_pkg::ELEM_MIN)
                         || (res_one == m4ct_pkg::ELEM_MAX) || (res_one == m4ct_pkg::ELEM_MIN)
                         || (res_two == m4ct_pkg::ELEM_MAX) || (res_two == m4ct_pkg::ELEM_MIN)
                         || (res_three == m4ct_pkg::ELEM_MAX)
                         || (res_three == m4ct_pkg::ELEM_MIN);

    // A stalled result beat keeps its payload until it is taken.
    `M4CT_ASSERT_NEXT(a_out_hold, out_blocked, out_valid && $stable(res_bits), "held beat changed")

    // A clipped result shows at least one row sitting on a bound.
    `M4CT_ASSERT_SAME(a_sat_bound, out_valid && saturated, at_bound, "flag without a bound row")

    // The input side only backs up once the whole chain is full behind a blocked result.
    `M4CT_ASSERT_SAME(a_stall_cause, stall, out_blocked, "input stalled while output drains")

endmodule

bind matrix4_column_transform_core m4ct_checker u_m4ct_checker (.*);

>>> test/matrix4_column_transform_core_test.sv
// Self-checking testbench for the streaming 4x4 column transform core.
module matrix4_column_transform_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC_BITS      = 16;
    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned RANDOM_ITEMS   = 1400;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SEND_IDLE_PCT [4] = '{0, 82, 0, 30};
    localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 82, 30};
    localparam m4ct_pkg::elem_t Q_ONE = 32'sh0001_0000;

    typedef m4ct_pkg::elem_t column_t [m4ct_pkg::ROWS];

    typedef struct {
        logic [m4ct_pkg::COL_W-1:0] col;
        column_t                    res;
        logic                       sat;
    } column_result_t;

    class column_product_scoreboard #(int unsigned FRAC = 16);
        localparam logic signed [65:0] RES_HI = 66'sd2147483647;
        localparam logic signed [65:0] RES_LO = -66'sd2147483648;
        localparam int unsigned MAX_PRINTS = 40;

        m4ct_pkg::elem_t left_store[m4ct_pkg::ROWS*m4ct_pkg::ROWS];
        column_result_t  expected_columns[$];
        int unsigned     loads_noted;
        int unsigned     transforms_noted;
        int unsigned     clipped_predicted;
        int unsigned     results_checked;
        int unsigned     mismatches;

        function new();
            foreach (left_store[i])
                left_store[i] = '0;
        endfunction

        // Exact dot product of each stored row with the vector, floored and clamped.
        function column_result_t product_column(logic [m4ct_pkg::COL_W-1:0] tag,
                                                column_t vec);
            column_result_t r;
            logic signed [65:0] acc;
            logic signed [65:0] shifted;
            longint prod;
            r.col = tag;
            r.sat = 1'b0;
            for (int row = 0; row < m4ct_pkg::ROWS; row++)
            begin
                acc = '0;
                for (int c = 0; c < m4ct_pkg::ROWS; c++)
                begin
                    prod = longint'(left_store[c*m4ct_pkg::ROWS + row]) * longint'(vec[c]);
                    acc += prod;
                end
                shifted = acc >>> FRAC;
                if (shifted > RES_HI)
                begin
                    r.res[row] = m4ct_pkg::ELEM_MAX;
                    r.sat = 1'b1;
                end
                else if (shifted < RES_LO)
                begin
                    r.res[row] = m4ct_pkg::ELEM_MIN;
                    r.sat = 1'b1;
                end
                else
                begin
                    r.res[row] = m4ct_pkg::elem_t'(shifted[m4ct_pkg::ELEM_W-1:0]);
                end
            end
            return r;
        endfunction

        function void accept_beat(logic k, logic [m4ct_pkg::COL_W-1:0] c, column_t vec);
            column_result_t r;
            if (k == m4ct_pkg::KIND_LOAD)
            begin
                for (int row = 0; row < m4ct_pkg::ROWS; row++)
                    left_store[c*m4ct_pkg::ROWS + row] = vec[row];
                loads_noted++;
            end
            else
            begin
                r = product_column(c, vec);
                if (r.sat)
                    clipped_predicted++;
                expected_columns.push_back(r);
                transforms_noted++;
            end
        endfunction

        task report_mismatch(string what, longint got, longint want);
            if (mismatches < MAX_PRINTS)
                $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_column(logic [m4ct_pkg::COL_W-1:0] tag, m4ct_pkg::elem_t r0,
                          m4ct_pkg::elem_t r1, m4ct_pkg::elem_t r2, m4ct_pkg::elem_t r3,
                          logic sat);
            column_result_t want;
            column_t got;
            got = '{r0, r1, r2, r3};
            results_checked++;
            if (expected_columns.size() == 0)
            begin
                report_mismatch("result beat with nothing expected, tag", tag, -1);
                return;
            end
            want = expected_columns.pop_front();
            if (tag !== want.col)
                report_mismatch("out_col", tag, want.col);
            for (int row = 0; row < m4ct_pkg::ROWS; row++)
                if (got[row] !== want.res[row])
                    report_mismatch($sformatf("result row %0d", row), got[row], want.res[row]);
            if (sat !== want.sat)
                report_mismatch("saturated", sat, want.sat);
        endtask
    endclass

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       valid      = 1'b0;
    logic                       stall;
    logic                       kind       = m4ct_pkg::KIND_LOAD;
    logic [m4ct_pkg::COL_W-1:0] col        = '0;
    m4ct_pkg::elem_t            elem_zero  = '0;
    m4ct_pkg::elem_t            elem_one   = '0;
    m4ct_pkg::elem_t            elem_two   = '0;
    m4ct_pkg::elem_t            elem_three = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic [m4ct_pkg::COL_W-1:0] out_col;
    m4ct_pkg::elem_t            res_zero;
    m4ct_pkg::elem_t            res_one;
    m4ct_pkg::elem_t            res_two;
    m4ct_pkg::elem_t            res_three;
    logic                       saturated;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent     = 0;
    int unsigned idle_cycles    = 0;

    column_product_scoreboard #(FRAC_BITS) sb;

    matrix4_column_transform_core #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (valid),
        .stall      (stall),
        .kind       (kind),
        .col        (col),
        .elem_zero  (elem_zero),
        .elem_one   (elem_one),
        .elem_two   (elem_two),
        .elem_three (elem_three),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_col    (out_col),
        .res_zero   (res_zero),
        .res_one    (res_one),
        .res_two    (res_two),
        .res_three  (res_three),
        .saturated  (saturated)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Results are checked before inputs are noted, so a beat accepted on the same edge
    // can never be matched against its own result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_column(out_col, res_zero, res_one, res_two, res_three, saturated);
        if (rst_n && valid && !stall)
            sb.accept_beat(kind, col, '{elem_zero, elem_one, elem_two, elem_three});
    end

    always @(posedge clk)
    begin
        idle_cycles <= ((valid && !stall) || (out_valid && !out_stall)) ? 0 : idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic m4ct_pkg::elem_t random_elem();
        case ($urandom_range(0, 9))
            0: return m4ct_pkg::ELEM_MAX;
            1: return m4ct_pkg::ELEM_MIN;
            2: return '0;
            3, 4: return m4ct_pkg::elem_t'($urandom());
            default: return m4ct_pkg::elem_t'($urandom_range(0, 32'h000F_FFFF))
                            - m4ct_pkg::elem_t'(32'h0008_0000);
        endcase
    endfunction

    function automatic column_t random_column();
        column_t v;
        foreach (v[i])
            v[i] = random_elem();
        return v;
    endfunction

    task automatic drive_beat(input logic k, input logic [m4ct_pkg::COL_W-1:0] c,
                              input column_t v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            valid <= 1'b0;
            @(posedge clk);
        end
        valid      <= 1'b1;
        kind       <= k;
        col        <= c;
        elem_zero  <= v[0];
        elem_one   <= v[1];
        elem_two   <= v[2];
        elem_three <= v[3];
        @(posedge clk);
        while (stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_columns.size() != 0);
    endtask

    initial
    begin : stimulus
        column_t     e;
        int unsigned phase_start;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A column that was never loaded acts as zero.
        drive_beat(m4ct_pkg::KIND_XFORM, 2'd3, '{m4ct_pkg::ELEM_MAX, m4ct_pkg::ELEM_MIN, -1, 1});

        // Identity matrix passes the extremes through unchanged.
        for (int c = 0; c < m4ct_pkg::ROWS; c++)
        begin
            e = '{default: '0};
            e[c] = Q_ONE;
            drive_beat(m4ct_pkg::KIND_LOAD, m4ct_pkg::COL_W'(c), e);
        end
        drive_beat(m4ct_pkg::KIND_XFORM, 2'd0, '{m4ct_pkg::ELEM_MAX, m4ct_pkg::ELEM_MIN, -1, 0});
        drive_beat(m4ct_pkg::KIND_XFORM, 2'd1, '{0, m4ct_pkg::ELEM_MAX, m4ct_pkg::ELEM_MIN, -1});
        drive_beat(m4ct_pkg::KIND_XFORM, 2'd2, '{-1, 0, m4ct_pkg::ELEM_MAX, m4ct_pkg::ELEM_MIN});
        drive_beat(m4ct_pkg::KIND_XFORM, 2'd3, '{1, -2, 32'sh1234_5678, -32'sh0001_8000});

        // All-minimum store: the sums overflow both ways and clip.
        for (int c = 0; c < m4ct_pkg::ROWS; c++)
            drive_beat(m4ct_pkg::KIND_LOAD, m4ct_pkg::COL_W'(c),
                       '{default: m4ct_pkg::ELEM_MIN});
        drive_beat(m4ct_pkg::KIND_XFORM, 2'd1, '{default: m4ct_pkg::ELEM_MIN});
        drive_beat(m4ct_pkg::KIND_XFORM, 2'd2, '{default: m4ct_pkg::ELEM_MAX});

        // Reload of one column takes effect on the very next beat; tiny negative
        // products must round toward minus infinity.
        drive_beat(m4ct_pkg::KIND_LOAD, 2'd0, '{1, -1, 3, -3});
        drive_beat(m4ct_pkg::KIND_XFORM, 2'd0, '{1, 0, 0, 0});

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_for_drain();
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            phase_start    = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS/4)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        // Full matrix product: load A column by column, then stream B.
                        for (int c = 0; c < m4ct_pkg::ROWS; c++)
                            drive_beat(m4ct_pkg::KIND_LOAD, m4ct_pkg::COL_W'(c),
                                       random_column());
                        for (int c = 0; c < m4ct_pkg::ROWS; c++)
                            drive_beat(m4ct_pkg::KIND_XFORM, m4ct_pkg::COL_W'(c),
                                       random_column());
                    end
                    6, 7:
                        drive_beat(($urandom_range(0, 1) != 0) ? m4ct_pkg::KIND_XFORM
                                                               : m4ct_pkg::KIND_LOAD,
                                   m4ct_pkg::COL_W'($urandom_range(0, 3)), random_column());
                    default:
                    begin
                        drive_beat(m4ct_pkg::KIND_LOAD, m4ct_pkg::COL_W'($urandom_range(0, 3)),
                                   random_column());
                        repeat ($urandom_range(1, 3))
                            drive_beat(m4ct_pkg::KIND_XFORM,
                                       m4ct_pkg::COL_W'($urandom_range(0, 3)),
                                       random_column());
                    end
                endcase
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d column loads and %0d transforms under four handshake patterns.",
                 sb.loads_noted, sb.transforms_noted);
        $display("Checked %0d result beats, %0d of them clipped; %0d field mismatches.",
                 sb.results_checked, sb.clipped_predicted, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_columns.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
